// File: src/ndie_pkg.sv
// package of shared constants for the nth decimal integer extractor
`timescale 1ns / 1ps
`default_nettype none

package ndie_pkg;

   // character codes
   localparam logic [7:0] CHAR_ZERO      = 8'd48;
   localparam logic [7:0] CHAR_NINE      = 8'd57;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;

   // scan phase codes
   localparam logic [1:0] PHASE_SEARCHING    = 2'd0;
   localparam logic [1:0] PHASE_ACCUMULATING = 2'd1;
   localparam logic [1:0] PHASE_DONE         = 2'd2;

   // field widths
   localparam int unsigned INDEX_WIDTH  = 16;
   localparam int unsigned STARTS_WIDTH = INDEX_WIDTH + 1;
   localparam int unsigned VALUE_WIDTH  = 32;

   localparam logic [STARTS_WIDTH-1:0] STARTS_MAX = {STARTS_WIDTH{1'b1}};

endpackage

`default_nettype wire

// File: src/nth_decimal_integer_extractor.sv
// nth decimal integer extractor: top level with scan state and result register
`timescale 1ns / 1ps
`default_nettype none

// Scans a text string one byte per request and, on the request flagged
// last_byte, returns the integer numbered csr_target_index (from 0) among the
// decimal integers in the string, with a found flag; the value is 0 if the
// integer is absent. An integer starts at a digit that is first in the
// string, follows a space, comma or semicolon, or follows a minus that is
// itself first or follows such a delimiter; that minus makes it negative.
// Digits accumulate until the first non-digit, wrapping at 32 bits. One
// request is taken every cycle unless a held response is not being taken:
// the scan state updates in the cycle of acceptance and the result of a
// final byte is loaded into the response register, which shows it in the
// cycle after its request and drains while the next request is taken. The
// user must write the target index through the csr port only while the
// block is idle; the block does not enforce this. The index is kept across
// strings. Scan state is cleared by reset and after every final byte.
module nth_decimal_integer_extractor (
   input  wire                clock,
   input  wire                reset,
   // configuration write
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [15:0]        csr_target_index,
   // text byte requests
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_text_byte,
   input  wire                req_last_byte,
   // results
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_int_value,
   output logic               rsp_found
);

   localparam int unsigned SW = ndie_pkg::STARTS_WIDTH;
   localparam int unsigned VW = ndie_pkg::VALUE_WIDTH;

   // configuration
   logic [ndie_pkg::INDEX_WIDTH-1:0] target_index_ff;

   // scan state
   logic [1:0]    char_position_ff, char_position_in;
   logic          prev_delim_ff, prev_delim_in;
   logic          prev_minus_ff, prev_minus_in;
   logic          prevprev_delim_ff, prevprev_delim_in;
   logic [SW-1:0] starts_seen_ff, starts_seen_in;
   logic [1:0]    phase_ff, phase_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic          negative_ff, negative_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_found_ff, rsp_found_in;

   // byte classification
   logic          req_fire;
   logic          is_digit;
   logic          is_delim;
   logic          is_minus;
   logic          is_start;
   logic [VW-1:0] digit_value;
   logic [VW-1:0] acc_times_ten;
   logic          next_found;

   assign csr_ready = 1'b1;

   // a request is taken whenever the response slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_digit = (req_text_byte >= ndie_pkg::CHAR_ZERO) &&
                     (req_text_byte <= ndie_pkg::CHAR_NINE);
   assign is_delim = (req_text_byte == ndie_pkg::CHAR_SPACE) ||
                     (req_text_byte == ndie_pkg::CHAR_COMMA) ||
                     (req_text_byte == ndie_pkg::CHAR_SEMICOLON);
   assign is_minus = (req_text_byte == ndie_pkg::CHAR_MINUS);

   // digits 0x30..0x39 carry their value in the low nibble
   assign digit_value = {{(VW-4){1'b0}}, req_text_byte[3:0]};

   // start of an integer: first byte, after a delimiter, or after a minus
   // that is itself first or follows a delimiter
   assign is_start = is_digit &&
                     ((char_position_ff == 2'd0) || prev_delim_ff ||
                      (prev_minus_ff && ((char_position_ff == 2'd1) || prevprev_delim_ff)));

   // times ten as two shifts and an add
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      negative_in = negative_ff;

      unique case (phase_ff)
         ndie_pkg::PHASE_ACCUMULATING: begin
            if (is_digit) begin
               acc_in = acc_times_ten + digit_value;
            end else begin
               phase_in = ndie_pkg::PHASE_DONE;
            end
         end
         ndie_pkg::PHASE_SEARCHING: begin
            if (is_start && (starts_seen_ff == {1'b0, target_index_ff})) begin
               phase_in    = ndie_pkg::PHASE_ACCUMULATING;
               acc_in      = digit_value;
               negative_in = prev_minus_ff;
            end
         end
         default: begin
            // done: value already settled
         end
      endcase

      starts_seen_in = starts_seen_ff;
      if (is_start && (starts_seen_ff != ndie_pkg::STARTS_MAX)) begin
         starts_seen_in = starts_seen_ff + 1'b1;
      end

      prevprev_delim_in = prev_delim_ff;
      prev_delim_in     = is_delim;
      prev_minus_in     = is_minus;
      char_position_in  = (char_position_ff == 2'd2) ? char_position_ff
                                                     : char_position_ff + 2'd1;

      // result of a final byte
      next_found   = (phase_in != ndie_pkg::PHASE_SEARCHING);
      rsp_found_in = next_found;
      if (!next_found) begin
         rsp_value_in = '0;
      end else if (negative_in) begin
         rsp_value_in = '0 - acc_in;
      end else begin
         rsp_value_in = acc_in;
      end

      // response slot: loaded by a final byte, freed when taken
      priority if (req_fire && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_index_ff   <= '0;
         char_position_ff  <= 2'd0;
         prev_delim_ff     <= 1'b0;
         prev_minus_ff     <= 1'b0;
         prevprev_delim_ff <= 1'b0;
         starts_seen_ff    <= '0;
         phase_ff          <= ndie_pkg::PHASE_SEARCHING;
         acc_ff            <= '0;
         negative_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            target_index_ff <= csr_target_index;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            if (req_last_byte) begin
               // string ends: clear for the next one
               char_position_ff  <= 2'd0;
               prev_delim_ff     <= 1'b0;
               prev_minus_ff     <= 1'b0;
               prevprev_delim_ff <= 1'b0;
               starts_seen_ff    <= '0;
               phase_ff          <= ndie_pkg::PHASE_SEARCHING;
               acc_ff            <= '0;
               negative_ff       <= 1'b0;
            end else begin
               char_position_ff  <= char_position_in;
               prev_delim_ff     <= prev_delim_in;
               prev_minus_ff     <= prev_minus_in;
               prevprev_delim_ff <= prevprev_delim_in;
               starts_seen_ff    <= starts_seen_in;
               phase_ff          <= phase_in;
               acc_ff            <= acc_in;
               negative_ff       <= negative_in;
            end
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire && req_last_byte) begin
         rsp_value_ff <= rsp_value_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_int_value = rsp_value_ff;
   assign rsp_found     = rsp_found_ff;

endmodule

`default_nettype wire
